// ===== rtl/vlmd_pkg.sv =====
// Shared types, constants and helpers for the volume local-maximum detector.
// No dependencies; vlmd_walk and the top level in rtl/ import this package.
package vlmd_pkg;

  // Default sizing, handed to the top level as parameter defaults
  localparam int MAX_X_DEF      = 64;
  localparam int MAX_Y_DEF      = 64;
  localparam int MAX_Z_DEF      = 64;
  localparam int MAX_RADIUS_DEF = 7;

  localparam int COORD_W   = 7;   // extents and coordinates up to 127
  localparam int RAD_W     = 3;
  localparam int VOX_W     = 8;
  localparam int POS_W     = 6;
  localparam int CNT_W     = 19;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 8;

  // Item function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_SCAN = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CUT      = 3'd6;

  typedef struct packed {
    logic             func;
    logic [VOX_W-1:0] voxel;
  } vlmd_item_t;

  typedef struct packed {
    logic             is_max;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;
    logic [CNT_W-1:0] max_total;
    logic             last;
  } vlmd_res_t;

  // Clamped neighborhood window, inclusive bounds
  typedef struct packed {
    logic [COORD_W-1:0] lo_x;
    logic [COORD_W-1:0] lo_y;
    logic [COORD_W-1:0] lo_z;
    logic [COORD_W-1:0] hi_x;
    logic [COORD_W-1:0] hi_y;
    logic [COORD_W-1:0] hi_z;
  } vlmd_win_t;

  typedef struct packed {
    logic load;   // take the window start address
    logic adv;    // step to the next window voxel
  } vlmd_walk_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADDR,
    ST_CRD,
    ST_CWAIT,
    ST_SWEEP,
    ST_DRAIN,
    ST_FIN
  } vlmd_state_e;

  function automatic logic [VOX_W-1:0] vlmd_cut(input logic [VOX_W-1:0] v,
                                                input logic [VOX_W-1:0] lvl);
    return (v < lvl) ? '0 : v;
  endfunction

  function automatic logic [COORD_W-1:0] vlmd_win_lo(input logic [COORD_W-1:0] c,
                                                     input logic [RAD_W-1:0]   r);
    logic [COORD_W-1:0] rr;
    rr = COORD_W'(r);
    return (c > rr) ? (c - rr) : '0;
  endfunction

  function automatic logic [COORD_W-1:0] vlmd_win_hi(input logic [COORD_W-1:0] c,
                                                     input logic [RAD_W-1:0]   r,
                                                     input logic [COORD_W-1:0] d);
    logic [COORD_W:0] sum;
    logic [COORD_W:0] lim;
    sum = {1'b0, c} + (COORD_W + 1)'(r);
    lim = {1'b0, d} - (COORD_W + 1)'(1);
    return (sum > lim) ? lim[COORD_W-1:0] : sum[COORD_W-1:0];
  endfunction

endpackage

// ===== rtl/vlmd_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module vlmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/vlmd_walk.sv =====
// Neighborhood address walker: steps through the clamped box around the
// examined voxel, z innermost, keeping running linear addresses.
// Depends on vlmd_pkg.
module vlmd_walk #(
  parameter int ADDR_W = 18
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  vlmd_pkg::vlmd_walk_ctl_t          ctl_i,
  input  vlmd_pkg::vlmd_win_t               win_i,
  input  logic [ADDR_W-1:0]                 start_addr_i,
  input  logic [vlmd_pkg::COORD_W-1:0]      dx_i,
  input  logic [ADDR_W-1:0]                 dxdy_i,
  output logic [ADDR_W-1:0]                 addr_o,
  output logic                              at_end_o
);
  import vlmd_pkg::*;

  logic [COORD_W-1:0] nx_q, nx_d;
  logic [COORD_W-1:0] ny_q, ny_d;
  logic [COORD_W-1:0] nz_q, nz_d;
  // row_x: (nx, lo_y, lo_z); row_y: (nx, ny, lo_z); cur: (nx, ny, nz)
  logic [ADDR_W-1:0]  row_x_q, row_x_d;
  logic [ADDR_W-1:0]  row_y_q, row_y_d;
  logic [ADDR_W-1:0]  cur_q, cur_d;

  always_comb begin
    nx_d    = nx_q;
    ny_d    = ny_q;
    nz_d    = nz_q;
    row_x_d = row_x_q;
    row_y_d = row_y_q;
    cur_d   = cur_q;
    priority if (ctl_i.load) begin
      nx_d    = win_i.lo_x;
      ny_d    = win_i.lo_y;
      nz_d    = win_i.lo_z;
      row_x_d = start_addr_i;
      row_y_d = start_addr_i;
      cur_d   = start_addr_i;
    end else if (ctl_i.adv) begin
      priority if (nz_q != win_i.hi_z) begin
        nz_d  = nz_q + COORD_W'(1);
        cur_d = cur_q + dxdy_i;
      end else if (ny_q != win_i.hi_y) begin
        ny_d    = ny_q + COORD_W'(1);
        nz_d    = win_i.lo_z;
        row_y_d = row_y_q + ADDR_W'(dx_i);
        cur_d   = row_y_q + ADDR_W'(dx_i);
      end else begin
        nx_d    = nx_q + COORD_W'(1);
        ny_d    = win_i.lo_y;
        nz_d    = win_i.lo_z;
        row_x_d = row_x_q + ADDR_W'(1);
        row_y_d = row_x_q + ADDR_W'(1);
        cur_d   = row_x_q + ADDR_W'(1);
      end
    end else begin
      cur_d = cur_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nx_q <= '0;
      ny_q <= '0;
      nz_q <= '0;
    end else begin
      nx_q <= nx_d;
      ny_q <= ny_d;
      nz_q <= nz_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_x_q <= row_x_d;
    row_y_q <= row_y_d;
    cur_q   <= cur_d;
  end

  assign addr_o   = cur_q;
  assign at_end_o = (nx_q == win_i.hi_x) && (ny_q == win_i.hi_y) && (nz_q == win_i.hi_z);

endmodule

// ===== rtl/volume_local_maximum_detect_top.sv =====
// Volume local-maximum detector, top level. Instantiates vlmd_ram (voxel store)
// and vlmd_walk (neighborhood address walker); depends on vlmd_pkg.
//
// A load word writes the next voxel in raster order and restarts the scan.
// A scan word keeps the block busy until its result word is out, so no new
// item is taken before then; the single read port of the voxel store
// delivers one neighbor of the clamped box around the examined voxel
// (center included) per cycle. The sweep stops at the first strictly greater
// neighbor, and a voxel that is zero after the cut skips the sweep.
// res_valid_o marks the result word on res_o for exactly one cycle, in the
// first cycle that busy_o is low again; the receiver cannot stall it.
// The voxel store has no clearing pass. Configuration is taken only while the
// block is idle; after reset and after each configuration write busy_o stays
// high while the derived volume sizes settle.
module volume_local_maximum_detect_top #(
  parameter int MAX_X      = vlmd_pkg::MAX_X_DEF,
  parameter int MAX_Y      = vlmd_pkg::MAX_Y_DEF,
  parameter int MAX_Z      = vlmd_pkg::MAX_Z_DEF,
  parameter int MAX_RADIUS = vlmd_pkg::MAX_RADIUS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  vlmd_pkg::vlmd_item_t              item_i,
  output logic                              busy_o,
  output logic                              res_valid_o,
  output vlmd_pkg::vlmd_res_t               res_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [vlmd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [vlmd_pkg::CFG_DAT_W-1:0]    cfg_data_i
);
  import vlmd_pkg::*;

  localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Configuration registers
  logic [COORD_W-1:0] dim_x_q, dim_y_q, dim_z_q;
  logic [RAD_W-1:0]   rad_x_q, rad_y_q, rad_z_q;
  logic [VOX_W-1:0]   cut_q;

  // Effective geometry
  logic [COORD_W-1:0] dx, dy, dz;
  logic [RAD_W-1:0]   rx, ry, rz;
  logic [AW-1:0]      dxdy_q;
  logic [AW:0]        total_q;
  logic [1:0]         settle_q, settle_d;

  // Sequencer and state
  vlmd_state_e        state_q, state_d;
  logic [AW-1:0]      ld_idx_q, ld_idx_d;
  logic [COORD_W-1:0] sx_q, sx_d, sy_q, sy_d, sz_q, sz_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d, cnt_inc;
  logic               ok_q, ok_d;
  logic               chk_q, chk_d;
  logic               res_valid_q, res_valid_d;
  vlmd_res_t          res_q, res_d;

  // Datapath registers
  logic [AW-1:0]      prod_cy_q, prod_cz_q, prod_sy_q, prod_sz_q;
  logic [AW-1:0]      center_addr_q;
  logic [VOX_W-1:0]   center_q;

  logic               accept;
  logic               cfg_we;
  logic               pos_out;
  logic               last_pos;
  logic [AW-1:0]      ld_eff;
  logic [AW:0]        ld_inc;
  logic [AW-1:0]      ld_next;
  logic [AW-1:0]      start_addr;
  vlmd_win_t          win;
  vlmd_walk_ctl_t     walk_ctl;
  logic [AW-1:0]      walk_addr;
  logic               walk_end;
  logic               ram_we;
  logic [AW-1:0]      ram_raddr;
  logic [VOX_W-1:0]   ram_rdata;
  logic               greater;

  // ---------------------------------------------------------------------------
  // Geometry
  // ---------------------------------------------------------------------------
  always_comb begin
    dx = (dim_x_q == '0) ? COORD_W'(1) :
         ((32'(dim_x_q) > MAX_X) ? COORD_W'(MAX_X) : dim_x_q);
    dy = (dim_y_q == '0) ? COORD_W'(1) :
         ((32'(dim_y_q) > MAX_Y) ? COORD_W'(MAX_Y) : dim_y_q);
    dz = (dim_z_q == '0) ? COORD_W'(1) :
         ((32'(dim_z_q) > MAX_Z) ? COORD_W'(MAX_Z) : dim_z_q);
    rx = (32'(rad_x_q) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : rad_x_q;
    ry = (32'(rad_y_q) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : rad_y_q;
    rz = (32'(rad_z_q) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : rad_z_q;
  end

  // Sizes settle through dxdy_q and then total_q; settle_q holds the block busy meanwhile.
  always_ff @(posedge clk_i) begin
    dxdy_q  <= AW'(dx) * AW'(dy);
    total_q <= (AW + 1)'(dxdy_q) * (AW + 1)'(dz);
  end

  always_comb begin
    win.lo_x = vlmd_win_lo(sx_q, rx);
    win.lo_y = vlmd_win_lo(sy_q, ry);
    win.lo_z = vlmd_win_lo(sz_q, rz);
    win.hi_x = vlmd_win_hi(sx_q, rx, dx);
    win.hi_y = vlmd_win_hi(sy_q, ry, dy);
    win.hi_z = vlmd_win_hi(sz_q, rz, dz);
  end

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  assign busy_o      = (state_q != ST_IDLE) || (settle_q != 2'd0);
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = (state_q == ST_IDLE) && !accept;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign settle_d    = cfg_we ? 2'd2 : ((settle_q != 2'd0) ? settle_q - 2'd1 : 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_x_q <= COORD_W'(64);
      dim_y_q <= COORD_W'(64);
      dim_z_q <= COORD_W'(64);
      rad_x_q <= RAD_W'(1);
      rad_y_q <= RAD_W'(1);
      rad_z_q <= RAD_W'(1);
      cut_q   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        CFG_DIM_X:    dim_x_q <= cfg_data_i[COORD_W-1:0];
        CFG_DIM_Y:    dim_y_q <= cfg_data_i[COORD_W-1:0];
        CFG_DIM_Z:    dim_z_q <= cfg_data_i[COORD_W-1:0];
        CFG_RADIUS_X: rad_x_q <= cfg_data_i[RAD_W-1:0];
        CFG_RADIUS_Y: rad_y_q <= cfg_data_i[RAD_W-1:0];
        CFG_RADIUS_Z: rad_z_q <= cfg_data_i[RAD_W-1:0];
        CFG_CUT:      cut_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Load addressing and scan position checks
  // ---------------------------------------------------------------------------
  always_comb begin
    ld_eff  = ({1'b0, ld_idx_q} >= total_q) ? '0 : ld_idx_q;
    ld_inc  = {1'b0, ld_eff} + (AW + 1)'(1);
    ld_next = (ld_inc >= total_q) ? '0 : ld_inc[AW-1:0];
  end

  assign pos_out  = (sx_q >= dx) || (sy_q >= dy) || (sz_q >= dz);
  assign last_pos = (sx_q == dx - COORD_W'(1)) && (sy_q == dy - COORD_W'(1)) &&
                    (sz_q == dz - COORD_W'(1));
  assign cnt_inc  = cnt_q + CNT_W'(1);
  assign greater  = chk_q && (center_q < vlmd_cut(ram_rdata, cut_q));

  assign start_addr = AW'(win.lo_x) + prod_sy_q + prod_sz_q;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    ld_idx_d    = ld_idx_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    sz_d        = sz_q;
    cnt_d       = cnt_q;
    ok_d        = ok_q;
    chk_d       = 1'b0;
    res_valid_d = 1'b0;
    res_d       = res_q;
    walk_ctl    = '0;
    ram_we      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (item_i.func == FUNC_SCAN) begin
            if (pos_out) begin
              sx_d  = '0;
              sy_d  = '0;
              sz_d  = '0;
              cnt_d = '0;
            end
            state_d = ST_MUL;
          end else begin
            ram_we   = 1'b1;
            ld_idx_d = ld_next;
            sx_d     = '0;
            sy_d     = '0;
            sz_d     = '0;
            cnt_d    = '0;
          end
        end
      end
      ST_MUL: begin
        state_d = ST_ADDR;
      end
      ST_ADDR: begin
        walk_ctl.load = 1'b1;
        state_d       = ST_CRD;
      end
      ST_CRD: begin
        state_d = ST_CWAIT;
      end
      ST_CWAIT: begin
        if (vlmd_cut(ram_rdata, cut_q) == '0) begin
          ok_d    = 1'b0;
          state_d = ST_FIN;
        end else begin
          ok_d    = 1'b1;
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (greater) begin
          ok_d    = 1'b0;
          state_d = ST_FIN;
        end else begin
          chk_d = 1'b1;
          if (walk_end) begin
            state_d = ST_DRAIN;
          end else begin
            walk_ctl.adv = 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (greater) begin
          ok_d = 1'b0;
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        res_valid_d     = 1'b1;
        res_d.is_max    = ok_q;
        res_d.pos_x     = sx_q[POS_W-1:0];
        res_d.pos_y     = sy_q[POS_W-1:0];
        res_d.pos_z     = sz_q[POS_W-1:0];
        res_d.max_total = ok_q ? cnt_inc : cnt_q;
        res_d.last      = last_pos;
        cnt_d           = ok_q ? cnt_inc : cnt_q;
        if (last_pos) begin
          sx_d  = '0;
          sy_d  = '0;
          sz_d  = '0;
          cnt_d = '0;
        end else if (sz_q + COORD_W'(1) < dz) begin
          sz_d = sz_q + COORD_W'(1);
        end else begin
          sz_d = '0;
          if (sy_q + COORD_W'(1) < dy) begin
            sy_d = sy_q + COORD_W'(1);
          end else begin
            sy_d = '0;
            sx_d = sx_q + COORD_W'(1);
          end
        end
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      settle_q    <= 2'd2;
      ld_idx_q    <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      sz_q        <= '0;
      cnt_q       <= '0;
      ok_q        <= 1'b0;
      chk_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      settle_q    <= settle_d;
      ld_idx_q    <= ld_idx_d;
      sx_q        <= sx_d;
      sy_q        <= sy_d;
      sz_q        <= sz_d;
      cnt_q       <= cnt_d;
      ok_q        <= ok_d;
      chk_q       <= chk_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Address products for the center and the window corner
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      prod_cy_q <= AW'(sy_q) * AW'(dx);
      prod_cz_q <= AW'(sz_q) * dxdy_q;
      prod_sy_q <= AW'(win.lo_y) * AW'(dx);
      prod_sz_q <= AW'(win.lo_z) * dxdy_q;
    end
    if (state_q == ST_ADDR) begin
      center_addr_q <= AW'(sx_q) + prod_cy_q + prod_cz_q;
    end
    if (state_q == ST_CWAIT) begin
      center_q <= vlmd_cut(ram_rdata, cut_q);
    end
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // ---------------------------------------------------------------------------
  // Voxel store and window walker
  // ---------------------------------------------------------------------------
  // Loads write only in idle, and a scan reads only from ST_CRD on, after its MUL
  // and ADDR states, so a write and a read of the same entry never overlap.
  assign ram_raddr = (state_q == ST_CRD) ? center_addr_q : walk_addr;

  vlmd_ram #(
    .WIDTH (VOX_W),
    .DEPTH (DEPTH)
  ) u_vol_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ld_eff),
    .wdata_i (item_i.voxel),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  vlmd_walk #(
    .ADDR_W (AW)
  ) u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (walk_ctl),
    .win_i        (win),
    .start_addr_i (start_addr),
    .dx_i         (dx),
    .dxdy_i       (dxdy_q),
    .addr_o       (walk_addr),
    .at_end_o     (walk_end)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_res_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(state_q == ST_FIN))
    else $error("result strobe without a finished scan");

  a_write_idle_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_IDLE) && (settle_q == 2'd0))
    else $error("voxel store written outside idle");

  a_sweep_in_volume: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> ({1'b0, walk_addr} < total_q))
    else $error("neighbor address outside the volume");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("back-to-back result strobes");

endmodule

// ===== tb/sv/tb_volume_local_maximum_detect_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for volume_local_maximum_detect_top: loads small volumes,
// scans them under many extent/radius/cut settings and checks every result word.
// Depends on vlmd_pkg and the RTL under rtl/.
module tb_volume_local_maximum_detect_top;
  import vlmd_pkg::*;

  localparam int VOL_X = MAX_X_DEF;
  localparam int VOL_Y = MAX_Y_DEF;
  localparam int VOL_Z = MAX_Z_DEF;
  localparam int VOL_DEPTH = VOL_X * VOL_Y * VOL_Z;
  localparam int RAD_MAX = MAX_RADIUS_DEF;
  localparam int ITEM_TARGET = 1250;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 400;
  localparam int DRAIN_GUARD = 20000;
  localparam int IDLE_PCT [4] = '{0, 56, 0, 33};
  localparam logic [VOX_W-1:0] SEED_VOX [8] = '{8'd255, 8'd0, 8'd128, 8'd1,
                                                8'd255, 8'hAA, 8'h55, 8'h7F};

  // Predicts the detector: voxel store, load pointer, scan position and count.
  class MaxDetectScoreboard;
    bit [VOX_W-1:0] voxels [VOL_DEPTH];
    bit             loaded [VOL_DEPTH];
    int unsigned load_ptr, scan_x, scan_y, scan_z, max_count;
    int unsigned dim_x, dim_y, dim_z, rad_x, rad_y, rad_z, cut;
    vlmd_res_t   expected_q [$];
    int unsigned mismatches;

    function new();
      load_ptr = 0; scan_x = 0; scan_y = 0; scan_z = 0; max_count = 0;
      dim_x = 64; dim_y = 64; dim_z = 64;
      rad_x = 1; rad_y = 1; rad_z = 1;
      cut = 0;
      mismatches = 0;
    endfunction

    function int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
    endfunction

    function int clamp_rad(int unsigned v);
      return (v > RAD_MAX) ? RAD_MAX : int'(v);
    endfunction

    function void extents(output int unsigned dx, output int unsigned dy,
                          output int unsigned dz);
      dx = clamp_dim(dim_x, VOL_X);
      dy = clamp_dim(dim_y, VOL_Y);
      dz = clamp_dim(dim_z, VOL_Z);
    endfunction

    function int unsigned volume_size();
      int unsigned dx, dy, dz;
      extents(dx, dy, dz);
      return dx * dy * dz;
    endfunction

    // True when every voxel a scan can touch has been written
    function bit fully_loaded();
      int unsigned total;
      total = volume_size();
      for (int unsigned i = 0; i < total; i++)
        if (!loaded[i]) return 1'b0;
      return 1'b1;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        CFG_DIM_X:    dim_x = 32'(data & 8'h7F);
        CFG_DIM_Y:    dim_y = 32'(data & 8'h7F);
        CFG_DIM_Z:    dim_z = 32'(data & 8'h7F);
        CFG_RADIUS_X: rad_x = 32'(data & 8'h07);
        CFG_RADIUS_Y: rad_y = 32'(data & 8'h07);
        CFG_RADIUS_Z: rad_z = 32'(data & 8'h07);
        CFG_CUT:      cut = 32'(data);
        default: ;
      endcase
    endfunction

    function int unsigned cut_voxel(int unsigned idx);
      return (voxels[idx] < cut) ? 0 : voxels[idx];
    endfunction

    function void note_item(vlmd_item_t it);
      int unsigned dx, dy, dz, total, center;
      int rx, ry, rz, nx, ny, nz;
      bit peak, at_end;
      vlmd_res_t r;
      extents(dx, dy, dz);
      total = dx * dy * dz;
      if (it.func != FUNC_SCAN) begin
        if (load_ptr >= total) load_ptr = 0;
        voxels[load_ptr] = it.voxel;
        loaded[load_ptr] = 1'b1;
        load_ptr++;
        if (load_ptr >= total) load_ptr = 0;
        scan_x = 0; scan_y = 0; scan_z = 0; max_count = 0;
        return;
      end
      // position left outside shrunk extents: start over
      if (scan_x >= dx || scan_y >= dy || scan_z >= dz) begin
        scan_x = 0; scan_y = 0; scan_z = 0; max_count = 0;
      end
      rx = clamp_rad(rad_x);
      ry = clamp_rad(rad_y);
      rz = clamp_rad(rad_z);
      center = cut_voxel(scan_x + scan_y * dx + scan_z * dx * dy);
      peak = (center != 0);
      for (int a = -rx; a <= rx; a++) begin
        for (int b = -ry; b <= ry; b++) begin
          for (int c = -rz; c <= rz; c++) begin
            nx = int'(scan_x) + a;
            ny = int'(scan_y) + b;
            nz = int'(scan_z) + c;
            if (nx < 0 || nx >= int'(dx) || ny < 0 || ny >= int'(dy) ||
                nz < 0 || nz >= int'(dz) || (a == 0 && b == 0 && c == 0))
              continue;
            if (center < cut_voxel(nx + ny * dx + nz * dx * dy)) peak = 1'b0;
          end
        end
      end
      if (peak) max_count = (max_count + 1) & 32'h7FFFF;
      at_end = (scan_x == dx - 1) && (scan_y == dy - 1) && (scan_z == dz - 1);
      r.is_max    = peak;
      r.pos_x     = POS_W'(scan_x);
      r.pos_y     = POS_W'(scan_y);
      r.pos_z     = POS_W'(scan_z);
      r.max_total = CNT_W'(max_count);
      r.last      = at_end;
      expected_q.push_back(r);
      if (at_end) begin
        scan_x = 0; scan_y = 0; scan_z = 0; max_count = 0;
      end else begin
        scan_z++;
        if (scan_z >= dz) begin
          scan_z = 0;
          scan_y++;
          if (scan_y >= dy) begin
            scan_y = 0;
            scan_x++;
          end
        end
      end
    endfunction

    function void report(string what, vlmd_res_t want, vlmd_res_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%s: expected max=%0d pos=(%0d,%0d,%0d) total=%0d last=%0d, ",
                 what, want.is_max, want.pos_x, want.pos_y, want.pos_z,
                 want.max_total, want.last,
                 "got max=%0d pos=(%0d,%0d,%0d) total=%0d last=%0d",
                 got.is_max, got.pos_x, got.pos_y, got.pos_z, got.max_total,
                 got.last);
    endfunction

    function void check_result(vlmd_res_t got);
      vlmd_res_t want;
      if (expected_q.size() == 0) begin
        report("result word with none pending", '0, got);
        return;
      end
      want = expected_q.pop_front();
      if (got.is_max !== want.is_max || got.pos_x !== want.pos_x ||
          got.pos_y !== want.pos_y || got.pos_z !== want.pos_z ||
          got.max_total !== want.max_total || got.last !== want.last)
        report("result word mismatch", want, got);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  vlmd_item_t           item_i = '0;
  logic                 busy_o;
  logic                 res_valid_o;
  vlmd_res_t            res_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;

  MaxDetectScoreboard board = new();
  int          idle_pct = 0;
  int unsigned items_sent = 0;

  volume_local_maximum_detect_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .item_i      (item_i),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) board.check_result(res_o);
  end

  initial begin
    #50_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // All tasks start and return right after a rising edge.
  task automatic send_item(input vlmd_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= it;
    do @(posedge clk_i); while (busy_o);
    board.note_item(it);
    items_sent++;
  endtask

  task automatic send_load(input logic [VOX_W-1:0] v);
    vlmd_item_t it;
    it.func  = FUNC_LOAD;
    it.voxel = v;
    send_item(it);
  endtask

  task automatic send_scan();
    vlmd_item_t it;
    it.func  = FUNC_SCAN;
    it.voxel = VOX_W'($urandom_range(0, 255));   // don't care on scans
    send_item(it);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_DAT_W'(data);
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, CFG_DAT_W'(data));
  endtask

  // Registers change only once the block has gone quiet.
  task automatic configure(input int unsigned dx, input int unsigned dy,
                           input int unsigned dz, input int unsigned rx,
                           input int unsigned ry, input int unsigned rz,
                           input int unsigned lvl);
    start_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(CFG_DIM_X, dx);
    write_reg(CFG_DIM_Y, dy);
    write_reg(CFG_DIM_Z, dz);
    write_reg(CFG_RADIUS_X, rx);
    write_reg(CFG_RADIUS_Y, ry);
    write_reg(CFG_RADIUS_Z, rz);
    write_reg(CFG_CUT, lvl);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [VOX_W-1:0] pick_voxel(input int unsigned profile);
    case (profile)
      0:       return VOX_W'($urandom_range(0, 255));
      1:       return VOX_W'($urandom_range(0, 3) * 85);
      default: return ($urandom_range(0, 7) == 0) ? VOX_W'($urandom_range(0, 255))
                                                  : 8'd100;
    endcase
  endfunction

  task automatic run_phase(input int phase_no);
    int unsigned d [3];
    int unsigned r [3];
    int unsigned lvl, total, profile, axis, nseg, shape, pick;
    idle_pct = IDLE_PCT[phase_no % 4];
    // first three phases stretch one axis to full size; phases 0 and 1 use extreme radii
    shape = (phase_no < 3) ? 0 : $urandom_range(0, 9);
    axis  = (phase_no < 3) ? phase_no : $urandom_range(0, 2);
    foreach (d[i]) d[i] = $urandom_range(1, 4);
    if (shape == 0) begin
      foreach (d[i]) d[i] = $urandom_range(0, 1);
      d[axis] = (phase_no == 0) ? 64 : $urandom_range(64, 127);
    end else if (shape == 1) begin
      d[axis] = 0;
    end
    foreach (r[i]) r[i] = (phase_no == 0) ? 7 : (phase_no == 1) ? 0 : $urandom_range(0, 7);
    pick = $urandom_range(0, 9);
    if (phase_no == 0 || (phase_no > 1 && pick < 4)) lvl = 0;
    else if (phase_no == 1 || pick == 4) lvl = 255;
    else lvl = $urandom_range(0, 255);
    profile = $urandom_range(0, 2);
    configure(d[0], d[1], d[2], r[0], r[1], r[2], lvl);

    total = board.volume_size();
    // keep the old contents now and then, so scans resume across a resize
    if (!board.fully_loaded() || $urandom_range(0, 1) == 0)
      repeat (total) send_load(pick_voxel(profile));
    nseg = $urandom_range(1, 3);
    repeat (nseg) begin
      if ($urandom_range(0, 9) < 7) begin
        repeat (total + $urandom_range(0, 3)) send_scan();
      end else begin
        repeat ($urandom_range(1, total + 2)) begin
          if ($urandom_range(0, 9) < 3) send_load(pick_voxel(profile));
          else send_scan();
        end
      end
    end
  endtask

  initial begin
    int phase_no;
    int guard;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 2x2x2 volume: extremes, a two-voxel plateau, wrap, load restart, cut
    configure(2, 2, 2, 1, 1, 1, 0);
    foreach (SEED_VOX[i]) send_load(SEED_VOX[i]);
    repeat (9) send_scan();
    send_load(8'd0);
    repeat (2) send_scan();
    configure(2, 2, 2, 1, 1, 1, 200);
    repeat (2) send_scan();

    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      run_phase(phase_no);
      phase_no++;
    end

    start_i <= 1'b0;
    guard = 0;
    while (board.pending() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
